[src/crb32_pkg.sv]
// ----------------------------------------------------------------------------
// crb32_pkg
// shared types for the crockford base32 identifier decoder
// ----------------------------------------------------------------------------
package crb32_pkg;

	// verdict codes carried on the status field
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BADCHAR = 2'd1,
		ST_LENGTH  = 2'd2
	} status_t;

	// one decoded symbol: 5-bit value and whether the character is in the alphabet
	typedef struct packed {
		logic       ok;
		logic [4:0] val;
	} sym_t;

	localparam int SYM_BITS  = 5;
	localparam int BYTE_BITS = 8;

	// offset between lower and upper case ascii letters
	localparam logic [7:0] CASE_OFFSET = 8'd32;

endpackage

[src/crb32_sym_decode.sv]
// ----------------------------------------------------------------------------
// crb32_sym_decode
// maps one ascii character to its crockford base32 symbol value
// ----------------------------------------------------------------------------
module crb32_sym_decode (
	input  logic [7:0]      char_code,
	output crb32_pkg::sym_t sym
);

	logic [7:0] up;

	always_comb begin
		// fold lower case onto upper case
		up = char_code;
		if (char_code inside {["a":"z"]}) begin
			up = char_code - crb32_pkg::CASE_OFFSET;
		end

		sym.ok  = 1'b1;
		sym.val = '0;
		case (up) inside
			["0":"9"]: sym.val = 5'(up - 8'("0"));
			["A":"H"]: sym.val = 5'(up - 8'("A") + 8'd10);
			"I", "L":  sym.val = 5'd1;
			["J":"K"]: sym.val = 5'(up - 8'("J") + 8'd18);
			["M":"N"]: sym.val = 5'(up - 8'("M") + 8'd20);
			"O":       sym.val = 5'd0;
			["P":"T"]: sym.val = 5'(up - 8'("P") + 8'd22);
			["V":"Z"]: sym.val = 5'(up - 8'("V") + 8'd27);
			default:   sym.ok  = 1'b0;  // U and anything outside the alphabet
		endcase
	end

endmodule

[src/crockford_base32_ulid_decoder.sv]
// ----------------------------------------------------------------------------
// crockford_base32_ulid_decoder
// Streaming Crockford base32 decoder for fixed-length text identifiers. One
// ASCII character is taken per beat; lower case is accepted, I and L read as
// 1, O reads as 0, and U or anything else is an invalid character. Each
// character adds 5 bits, most significant first, and every full 8 bits are
// returned as a byte together with its position. Every character beat gives
// exactly one result beat; the beat that carries end_of_string gives done_res
// and the verdict for the whole string in status (0 ok, 1 invalid character,
// 2 wrong length), after which the decoder is clear for the next string. A
// string must hold exactly STRING_LENGTH characters and yield exactly
// BYTE_COUNT bytes; leftover bits at the end are dropped. Throughput is one
// character per clock while results are taken: each character is decoded
// into an input register, then the accumulator logic updates the running
// state and fills the result register, which offers the result. The input
// register takes one more character while a result waits to be taken;
// after that char_ready stays low until the result is taken.
// ----------------------------------------------------------------------------
module crockford_base32_ulid_decoder #(
	parameter int STRING_LENGTH = 26,
	parameter int BYTE_COUNT    = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	// character channel
	input  logic       char_valid,
	output logic       char_ready,
	input  logic [7:0] char_code,
	input  logic       end_of_string,
	// result channel
	output logic       res_valid,
	input  logic       res_ready,
	output logic       byte_valid,
	output logic [7:0] data_byte,
	output logic [3:0] byte_index,
	output logic       done_res,
	output logic [1:0] status
);

	// character count saturates one past the nominal length
	localparam int CW = $clog2(STRING_LENGTH + 2);
	localparam int OW = $clog2(BYTE_COUNT + 1);
	localparam logic [CW-1:0] STR_LEN   = CW'(STRING_LENGTH);
	localparam logic [CW-1:0] STR_OVER  = CW'(STRING_LENGTH + 1);
	localparam logic [OW-1:0] BYTE_CNT  = OW'(BYTE_COUNT);

	// ---------------- input stage: symbol lookup into register ----------------
	crb32_pkg::sym_t sym_in;
	crb32_pkg::sym_t sym_s1;
	logic            eos_s1;
	logic            valid_s1;
	logic            adv;       // stage 1 moves into the result register

	crb32_sym_decode u_sym (
		.char_code (char_code),
		.sym       (sym_in)
	);

	assign adv        = valid_s1 && (!res_valid || res_ready);
	assign char_ready = !valid_s1 || !res_valid || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			sym_s1 <= sym_in;
			eos_s1 <= end_of_string;
		end
	end

	// ---------------- running string state ----------------
	logic [6:0]          lbits_q;   // leftover bits not yet forming a byte
	logic [2:0]          lcnt_q;    // how many leftover bits are held
	logic [CW-1:0]       ccnt_q;    // characters seen in this string
	logic [OW-1:0]       opos_q;    // bytes emitted in this string
	crb32_pkg::status_t  err_q;     // error latched so far

	// next-state and result logic
	logic [CW-1:0]       cc_nx;
	logic [OW-1:0]       op_nx;
	logic [6:0]          lb_nx;
	logic [2:0]          lc_nx;
	crb32_pkg::status_t  err_nx;
	logic [11:0]         acc;
	logic [3:0]          cnt;
	logic [2:0]          rem;
	logic                emit;
	logic [7:0]          bval;
	logic [OW+3:0]       op_ext;

	assign acc    = {lbits_q, sym_s1.val};
	assign cnt    = {1'b0, lcnt_q} + 4'(crb32_pkg::SYM_BITS);
	// bits left after the byte leaves, or all of them when no byte is complete
	assign rem    = cnt[2:0];
	assign op_ext = {4'b0, opos_q};

	always_comb begin
		cc_nx  = ccnt_q;
		op_nx  = opos_q;
		lb_nx  = lbits_q;
		lc_nx  = lcnt_q;
		err_nx = err_q;
		emit   = 1'b0;
		bval   = '0;

		if (ccnt_q <= STR_LEN) begin
			cc_nx = ccnt_q + CW'(1);
		end
		// too many characters: everything up to the end mark is swallowed
		if (cc_nx > STR_LEN) begin
			err_nx = crb32_pkg::ST_LENGTH;
		end

		if (err_nx == crb32_pkg::ST_OK) begin
			if (!sym_s1.ok) begin
				err_nx = crb32_pkg::ST_BADCHAR;
			end else begin
				if (cnt[3]) begin
					// a full byte has gathered
					if (opos_q >= BYTE_CNT) begin
						err_nx = crb32_pkg::ST_LENGTH;
					end else begin
						emit  = 1'b1;
						bval  = 8'(acc >> rem);
						op_nx = opos_q + OW'(1);
					end
				end
				lb_nx = 7'(acc & ((12'd1 << rem) - 12'd1));
				lc_nx = rem;
			end
		end

		// end mark: the count of characters and bytes must both be exact
		if (eos_s1 && (cc_nx != STR_LEN || op_nx != BYTE_CNT)) begin
			err_nx = crb32_pkg::ST_LENGTH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lbits_q <= '0;
			lcnt_q  <= '0;
			ccnt_q  <= '0;
			opos_q  <= '0;
			err_q   <= crb32_pkg::ST_OK;
		end else if (adv) begin
			if (eos_s1) begin
				// string finished: clear for the next one
				lbits_q <= '0;
				lcnt_q  <= '0;
				ccnt_q  <= '0;
				opos_q  <= '0;
				err_q   <= crb32_pkg::ST_OK;
			end else begin
				lbits_q <= lb_nx;
				lcnt_q  <= lc_nx;
				ccnt_q  <= cc_nx;
				opos_q  <= op_nx;
				err_q   <= err_nx;
			end
		end
	end

	// ---------------- result register ----------------
	logic       res_valid_q;
	logic       bvalid_q;
	logic [7:0] bval_q;
	logic [3:0] bidx_q;
	logic       done_q;
	logic [1:0] status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bvalid_q <= emit;
			bval_q   <= bval;
			bidx_q   <= emit ? op_ext[3:0] : 4'd0;
			done_q   <= eos_s1;
			status_q <= err_nx;
		end
	end

	assign res_valid  = res_valid_q;
	assign byte_valid = bvalid_q;
	assign data_byte  = bval_q;
	assign byte_index = bidx_q;
	assign done_res   = done_q;
	assign status     = status_q;

	// ---------------- assertions ----------------
	// a byte is never emitted after an invalid character was seen
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && byte_valid |-> status != crb32_pkg::ST_BADCHAR)
		else $error("byte emitted alongside invalid character status");

	// no leftover bit is set above the leftover count
	assert property (@(posedge clk) disable iff (!arst_n)
		(lbits_q >> lcnt_q) == 7'd0)
		else $error("leftover bits above leftover count");

	// counters stay inside their limits
	assert property (@(posedge clk) disable iff (!arst_n)
		opos_q <= BYTE_CNT && ccnt_q <= STR_OVER)
		else $error("string counters out of range");

	// the end mark leaves the decoder clear
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && eos_s1 |=> ccnt_q == '0 && opos_q == '0 && err_q == crb32_pkg::ST_OK)
		else $error("state not cleared after end of string");

endmodule

[tb/crockford_base32_ulid_decoder_test.sv]
// ----------------------------------------------------------------------------
// crockford_base32_ulid_decoder_test
// Self-checking bench for the Crockford base32 identifier decoder. A queue of
// characters (well-formed identifiers, identifiers with a bad character,
// short and long strings, raw noise) feeds a clocked driver. Each accepted
// beat runs through a local decoder model; a clocked monitor checks every
// result beat against the oldest prediction. Both sides idle at random in the
// first two of three phases, with one long receiver hold-off so the decoder backs up.
// ----------------------------------------------------------------------------
module crockford_base32_ulid_decoder_test;

	localparam int STRING_LENGTH = 26;
	localparam int BYTE_COUNT    = 16;
	localparam int TOTAL_CHARS   = 1680;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 10;
	localparam int CYCLE_LIMIT   = 200000;

	// one character beat as queued for the driver
	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} char_beat_t;

	// one result beat as predicted
	typedef struct packed {
		logic               byte_valid;
		logic [7:0]         data_byte;
		logic [3:0]         byte_index;
		logic               done_res;
		crb32_pkg::status_t status;
	} decode_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       char_valid = 1'b0;
	logic       char_ready;
	logic [7:0] char_code = 8'd0;
	logic       end_of_string = 1'b0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	logic       byte_valid;
	logic [7:0] data_byte;
	logic [3:0] byte_index;
	logic       done_res;
	logic [1:0] status;

	crockford_base32_ulid_decoder #(
		.STRING_LENGTH(STRING_LENGTH),
		.BYTE_COUNT   (BYTE_COUNT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_code    (char_code),
		.end_of_string(end_of_string),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.byte_valid   (byte_valid),
		.data_byte    (data_byte),
		.byte_index   (byte_index),
		.done_res     (done_res),
		.status       (status)
	);

	always #1 clk = ~clk;

	// characters waiting to be driven, and result beats waiting to be seen
	char_beat_t   char_stream[$];
	decode_beat_t decoded_beats[$];

	// decoder model state, at its reset value
	logic [6:0]         acc_bits   = 7'd0;
	logic [2:0]         acc_count  = 3'd0;
	logic [4:0]         chars_seen = 5'd0;
	logic [4:0]         bytes_out  = 5'd0;
	crb32_pkg::status_t verdict    = crb32_pkg::ST_OK;

	// symbols the generator draws from, aliases included
	string symbol_chars = "0123456789ABCDEFGHJKMNPQRSTVWXYZILO";

	int           beats_sent   = 0;
	int           error_count  = 0;
	int           cycle_count  = 0;
	int           strings_ok   = 0;
	int           strings_bad  = 0;
	int           strings_len  = 0;
	int           bytes_seen   = 0;
	int           hold_left    = 0;
	bit           held_once    = 1'b0;
	decode_beat_t want;
	decode_beat_t got;
	char_beat_t   next_char;

	// {in alphabet, 5-bit value} for one ascii code
	function automatic logic [5:0] symbol_of(logic [7:0] c);
		logic [7:0] u;
		u = c;
		if (u >= "a" && u <= "z")
			u = u - crb32_pkg::CASE_OFFSET;
		if (u >= "0" && u <= "9")
			return {1'b1, 5'(u - "0")};
		if (u >= "A" && u <= "H")
			return {1'b1, 5'(u - "A" + 8'd10)};
		if (u == "I" || u == "L")
			return {1'b1, 5'd1};
		if (u == "J" || u == "K")
			return {1'b1, 5'(u - "J" + 8'd18)};
		if (u == "M" || u == "N")
			return {1'b1, 5'(u - "M" + 8'd20)};
		if (u == "O")
			return {1'b1, 5'd0};
		if (u >= "P" && u <= "T")
			return {1'b1, 5'(u - "P" + 8'd22)};
		if (u >= "V" && u <= "Z")
			return {1'b1, 5'(u - "V" + 8'd27)};
		return 6'd0;
	endfunction

	// advance the model by one character and return its result beat
	function automatic decode_beat_t decode_char(logic [7:0] c, logic last);
		decode_beat_t r;
		logic [5:0]   sym;
		logic [11:0]  acc;
		logic [11:0]  shifted;
		logic [11:0]  kept;
		logic [3:0]   cnt;
		r = '0;
		if (chars_seen <= STRING_LENGTH)
			chars_seen = chars_seen + 5'd1;
		if (chars_seen > STRING_LENGTH)
			verdict = crb32_pkg::ST_LENGTH;
		if (verdict == crb32_pkg::ST_OK) begin
			sym = symbol_of(c);
			if (!sym[5]) begin
				verdict = crb32_pkg::ST_BADCHAR;
			end else begin
				acc = {acc_bits, sym[4:0]};
				cnt = {1'b0, acc_count} + 4'd5;
				if (cnt >= 4'd8) begin
					cnt = cnt - 4'd8;
					if (bytes_out >= BYTE_COUNT) begin
						verdict = crb32_pkg::ST_LENGTH;
					end else begin
						shifted = acc >> cnt;
						r.byte_valid = 1'b1;
						r.data_byte = shifted[7:0];
						r.byte_index = bytes_out[3:0];
						bytes_out = bytes_out + 5'd1;
					end
				end
				kept = acc & ((12'd1 << cnt) - 12'd1);
				acc_bits = kept[6:0];
				acc_count = cnt[2:0];
			end
		end
		if (last) begin
			r.done_res = 1'b1;
			if (chars_seen != STRING_LENGTH || bytes_out != BYTE_COUNT)
				verdict = crb32_pkg::ST_LENGTH;
		end
		r.status = verdict;
		if (last) begin
			acc_bits = 7'd0;
			acc_count = 3'd0;
			chars_seen = 5'd0;
			bytes_out = 5'd0;
			verdict = crb32_pkg::ST_OK;
		end
		return r;
	endfunction

	// a legal symbol, letters in either case
	function automatic logic [7:0] random_symbol();
		logic [7:0] c;
		c = symbol_chars[$urandom_range(0, symbol_chars.len() - 1)];
		if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1)
			c = c + crb32_pkg::CASE_OFFSET;
		return c;
	endfunction

	// a code outside the alphabet; U gets extra weight
	function automatic logic [7:0] random_invalid();
		logic [7:0] c;
		logic [5:0] sym;
		if ($urandom_range(0, 1) == 1)
			return ($urandom_range(0, 1) == 1) ? "U" : "u";
		do begin
			c = 8'($urandom_range(0, 255));
			sym = symbol_of(c);
		end while (sym[5]);
		return c;
	endfunction

	// queue one string; bad_at < 0 means no forced bad character
	task automatic push_string(int len, int bad_at, bit noise);
		char_beat_t b;
		for (int i = 0; i < len; i++) begin
			if (noise)
				b.code = 8'($urandom_range(0, 255));
			else if (i == bad_at)
				b.code = random_invalid();
			else
				b.code = random_symbol();
			b.last = (i == len - 1);
			char_stream.push_back(b);
		end
	endtask

	// idle percentages per phase: sender 28 / receiver 88, then swapped, then none
	function automatic int send_idle_pct(int sent);
		if (sent < TOTAL_CHARS / 3)
			return 28;
		if (sent < 2 * TOTAL_CHARS / 3)
			return 88;
		return 0;
	endfunction

	function automatic int recv_idle_pct(int sent);
		if (sent < TOTAL_CHARS / 3)
			return 88;
		if (sent < 2 * TOTAL_CHARS / 3)
			return 28;
		return 0;
	endfunction

	// driver: offers the next queued character, predicts on every accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
			char_code <= 8'd0;
			end_of_string <= 1'b0;
		end else if (!char_valid || char_ready) begin
			if (char_valid) begin
				decoded_beats.push_back(decode_char(char_code, end_of_string));
				beats_sent <= beats_sent + 1;
			end
			if (char_stream.size() != 0 &&
			    $urandom_range(0, 99) >= send_idle_pct(beats_sent)) begin
				next_char = char_stream.pop_front();
				char_valid <= 1'b1;
				char_code <= next_char.code;
				end_of_string <= next_char.last;
			end else begin
				char_valid <= 1'b0;
			end
		end
	end

	// monitor: checks each result beat and throttles res_ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				got.byte_valid = byte_valid;
				got.data_byte = data_byte;
				got.byte_index = byte_index;
				got.done_res = done_res;
				got.status = crb32_pkg::status_t'(status);
				if (decoded_beats.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result beat %p", $time, got);
				end else begin
					want = decoded_beats.pop_front();
					if (got !== want) begin
						error_count++;
						$display("%0t: result mismatch expected %p actual %p",
							$time, want, got);
					end
					if (want.byte_valid)
						bytes_seen++;
					if (want.done_res) begin
						case (want.status)
							crb32_pkg::ST_OK: strings_ok++;
							crb32_pkg::ST_BADCHAR: strings_bad++;
							default: strings_len++;
						endcase
					end
				end
			end
			// one long hold-off at the start of the no-idle phase
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				res_ready <= 1'b0;
			end else if (!held_once && beats_sent >= 2 * TOTAL_CHARS / 3) begin
				held_once <= 1'b1;
				hold_left <= HOLD_CYCLES;
				res_ready <= 1'b0;
			end else begin
				res_ready <= ($urandom_range(0, 99) >= recv_idle_pct(beats_sent));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		string pattern;
		char_beat_t b;
		int kind;
		int len;

		// directed: code extremes in a short string, a lone U, then a full
		// identifier mixing lower case with the I, L and O aliases
		b.code = 8'h00;
		b.last = 1'b0;
		char_stream.push_back(b);
		b.code = 8'hff;
		b.last = 1'b1;
		char_stream.push_back(b);
		b.code = "u";
		char_stream.push_back(b);
		pattern = "7ZzIiLlOo0123456789abcdefg";
		for (int i = 0; i < pattern.len(); i++) begin
			b.code = pattern[i];
			b.last = (i == pattern.len() - 1);
			char_stream.push_back(b);
		end

		// random: mostly well-formed identifiers, some broken or noise
		while (char_stream.size() < TOTAL_CHARS) begin
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				push_string(STRING_LENGTH, -1, 1'b0);
			end else if (kind < 72) begin
				push_string(STRING_LENGTH, $urandom_range(0, STRING_LENGTH - 1), 1'b0);
			end else if (kind < 82) begin
				push_string($urandom_range(1, STRING_LENGTH - 1), -1, 1'b0);
			end else if (kind < 92) begin
				len = $urandom_range(STRING_LENGTH + 1, STRING_LENGTH + 14);
				if ($urandom_range(0, 3) == 0)
					push_string(len, $urandom_range(0, len - 1), 1'b0);
				else
					push_string(len, -1, 1'b0);
			end else begin
				push_string($urandom_range(1, STRING_LENGTH + 14), -1, 1'b1);
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the last beat to be taken, then for every result
		@(posedge clk);
		while (char_stream.size() != 0 || char_valid)
			@(posedge clk);
		while (decoded_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d characters: %0d strings ok, %0d bad character, %0d wrong length",
			beats_sent, strings_ok, strings_bad, strings_len);
		$display("checked %0d decoded bytes, %0d mismatches", bytes_seen, error_count);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[sim.f]
src/crb32_pkg.sv
src/crb32_sym_decode.sv
src/crockford_base32_ulid_decoder.sv
tb/crockford_base32_ulid_decoder_test.sv
